>>> design/hnm_pkg.sv
// Shared types, constants and the channel scaling function for the
// height-to-normal-map block. No dependencies.
package hnm_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;

	localparam int unsigned CFG_WIDTH_W  = 11;
	localparam int unsigned CFG_HEIGHT_W = 13;
	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	localparam int unsigned OUT_DEPTH = 4;

	localparam logic [7:0]  BLUE_LEVEL  = 8'd255;
	localparam logic [7:0]  CH_MIN      = 8'd102;
	localparam logic [7:0]  CH_MAX      = 8'd154;
	localparam logic [10:0] MID_OFFSET  = 11'd1280;
	localparam logic [12:0] DIV10_RECIP = 13'd6554;
	localparam int unsigned DIV10_SHIFT = 16;
	localparam logic [10:0] TEN         = 11'd10;
	localparam logic [10:0] HALF_TEN    = 11'd5;

	// One line buffer entry: the row before last and the last row.
	typedef struct packed {
		logic [7:0] older;
		logic [7:0] prev;
	} row_ent_t;

	typedef struct packed {
		logic active;
		logic wr;
		logic emit;
		logic above_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} s0_ctl_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic       last;
	} pix_t;

	// round((1280 + a - b) / 10) with ties to even. The quotient comes from a
	// reciprocal multiply that is exact for the 1025..1535 range seen here.
	function automatic logic [7:0] scale_diff(input logic [7:0] a, input logic [7:0] b);
		logic [10:0] v;
		logic [23:0] prod;
		logic [7:0]  q;
		logic [10:0] rem;
		logic        up;
		v    = MID_OFFSET + {3'b000, a} - {3'b000, b};
		prod = {13'b0, v} * {11'b0, DIV10_RECIP};
		q    = prod[DIV10_SHIFT +: 8];
		rem  = v - ({3'b000, q} * TEN);
		up   = (rem > HALF_TEN) || ((rem == HALF_TEN) && q[0]);
		return q + {7'b0, up};
	endfunction

endpackage

>>> design/hnm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies. A read at the address being written returns the old data.
module hnm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/hnm_seq.sv
// Raster position sequencer: column and row counters, drain flag, and the
// per-transaction control decode. Depends on hnm_pkg.
module hnm_seq import hnm_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    restart,
	input  logic                    accept,
	input  logic                    action,
	input  logic [CFG_WIDTH_W-1:0]  cfg_width,
	input  logic [CFG_HEIGHT_W-1:0] cfg_height,
	output s0_ctl_t                 ctl,
	output logic [AW-1:0]           col,
	output logic [AW-1:0]           nxt_col
);

	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned CWX = (CFG_WIDTH_W > WW) ? CFG_WIDTH_W : WW;
	localparam int unsigned CHX = (CFG_HEIGHT_W > HW) ? CFG_HEIGHT_W : HW;

	logic [AW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           draining_q;
	logic [CWX-1:0] w_ext;
	logic [CHX-1:0] h_ext;
	logic [WW-1:0]  eff_w;
	logic [HW-1:0]  eff_h;
	logic [WW-1:0]  col_inc;
	logic [HW-1:0]  row_inc;
	logic           wrap;
	logic           run;

	assign w_ext = CWX'(cfg_width);
	assign h_ext = CHX'(cfg_height);

	// A zero size counts as one and an oversize is clamped to the buffer size.
	always_comb begin
		if (w_ext == '0) begin
			eff_w = WW'(1);
		end else if (w_ext > CWX'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(w_ext);
		end
		if (h_ext == '0) begin
			eff_h = HW'(1);
		end else if (h_ext > CHX'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(h_ext);
		end
	end

	assign col_inc = WW'(col_q) + WW'(1);
	assign row_inc = HW'(row_q) + HW'(1);
	assign wrap    = (col_inc >= eff_w);
	assign nxt_col = wrap ? '0 : AW'(col_inc);
	assign col     = col_q;

	// Samples count only outside the drain, flushes only inside it.
	assign run = accept && (action ? draining_q : !draining_q);

	always_comb begin
		ctl.active   = run;
		ctl.wr       = run && !action;
		ctl.emit     = run && (action || (row_q != '0));
		ctl.above_ok = action ? (eff_h > HW'(1)) : (row_q > RW'(1));
		ctl.left_ok  = (col_q != '0);
		ctl.right_ok = !wrap;
		ctl.last     = action && wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (run) begin
			if (wrap) begin
				col_q <= '0;
				if (action) begin
					draining_q <= 1'b0;
					row_q      <= '0;
				end else if (row_inc >= eff_h) begin
					draining_q <= 1'b1;
				end else begin
					row_q <= RW'(row_inc);
				end
			end else begin
				col_q <= AW'(col_inc);
			end
		end
	end

endmodule

>>> design/hnm_fifo.sv
// Small register FIFO that holds finished pixels for the output channel.
// No dependencies.
module hnm_fifo #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] rdata,
	output logic [CW-1:0]    count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/height_to_normal_map.sv
// Output: emitting transactions pass the stage 1 register into a four-entry output FIFO,
// which decouples the output channel. Throughput: one transaction per cycle when
// sample_ready is high, with one line buffer RAM read per transaction at the next column.
// Reset: counters, drain flag and pipeline clear; width and height reset to 1024.
// The line buffer RAM is not cleared and is undefined until a row is written.
// Depends on hnm_pkg, hnm_seq, hnm_ram and hnm_fifo.
module height_to_normal_map import hnm_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic              action,
	input  logic [7:0]        height_sample,
	output logic              pixel_valid,
	input  logic              pixel_ready,
	output logic [7:0]        normal_red,
	output logic [7:0]        normal_green,
	output logic [7:0]        normal_blue,
	output logic              end_of_image
);

	localparam int unsigned AW   = $clog2(MAX_WIDTH);
	localparam int unsigned CNTW = $clog2(OUT_DEPTH + 1);
	localparam int unsigned EW   = $bits(row_ent_t);
	localparam int unsigned PXW  = $bits(pix_t);

	logic [CFG_WIDTH_W-1:0]  img_width_q;
	logic [CFG_HEIGHT_W-1:0] img_height_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	s0_ctl_t       ctl_s0;
	logic [AW-1:0] col_s0;
	logic [AW-1:0] nxt_s0;
	logic          accept;

	s0_ctl_t       ctl_s1;
	logic [AW-1:0] col_s1;
	logic [7:0]    below_s1;
	logic          self_s1;
	logic          byp_s1;
	row_ent_t      bypd_s1;

	row_ent_t      ent_q;
	logic [7:0]    lft_q;
	logic [EW-1:0] ram_rdata;
	logic          ram_we;
	row_ent_t      rd_ent;
	row_ent_t      wr_ent;
	logic [7:0]    above;
	logic [7:0]    left_h;
	logic [7:0]    right_h;
	pix_t          pix;
	pix_t          head;
	logic [PXW-1:0] head_bits;
	logic [CNTW-1:0] fifo_cnt;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= WIDTH_RST;
			img_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  img_width_q  <= pwdata[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: img_height_q <= pwdata[CFG_HEIGHT_W-1:0];
				default:          img_width_q  <= img_width_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(img_width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(img_height_q);
			default:          prdata = '0;
		endcase
	end

	// Stage 0: position decode and prefetch of the next column's entry
	assign accept = sample_valid && sample_ready;

	hnm_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.accept     (accept),
		.action     (action),
		.cfg_width  (img_width_q),
		.cfg_height (img_height_q),
		.ctl        (ctl_s0),
		.col        (col_s0),
		.nxt_col    (nxt_s0)
	);

	assign ram_we = ctl_s1.wr;
	assign wr_ent = '{older: ent_q.prev, prev: below_s1};

	hnm_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (wr_ent),
		.re    (ctl_s0.active),
		.raddr (nxt_s0),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
		end
	end

	// The prefetch misses a write to the same entry in the same cycle, so that
	// write is captured and forwarded in stage 1.
	always_ff @(posedge clk) begin
		if (ctl_s0.active) begin
			col_s1   <= col_s0;
			below_s1 <= action ? 8'd0 : height_sample;
			self_s1  <= (nxt_s0 == col_s0);
			byp_s1   <= ram_we && (col_s1 == nxt_s0);
			bypd_s1  <= wr_ent;
		end
	end

	// Stage 1: neighbors, write-back and gradient
	assign rd_ent = byp_s1 ? bypd_s1 : row_ent_t'(ram_rdata);

	// ent_q is loaded in stage 1 with the entry of the column the next transaction lands on.
	// With a one-pixel row that is the entry this transaction writes.
	always_ff @(posedge clk) begin
		if (ctl_s1.active) begin
			lft_q <= ent_q.prev;
			ent_q <= (self_s1 && ctl_s1.wr) ? wr_ent : rd_ent;
		end
	end

	assign above   = ctl_s1.above_ok ? ent_q.older : 8'd0;
	assign left_h  = ctl_s1.left_ok ? lft_q : 8'd0;
	assign right_h = ctl_s1.right_ok ? rd_ent.prev : 8'd0;

	assign pix = '{
		red:   scale_diff(below_s1, above),
		green: scale_diff(left_h, right_h),
		last:  ctl_s1.last
	};

	hnm_fifo #(
		.WIDTH (PXW),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_s1.emit),
		.wdata     (pix),
		.out_valid (pixel_valid),
		.out_ready (pixel_ready),
		.rdata     (head_bits),
		.count     (fifo_cnt)
	);

	// Room is kept for the pixel in stage 1 and the one that may enter behind it.
	assign sample_ready = ({1'b0, fifo_cnt} + {{CNTW{1'b0}}, ctl_s1.emit})
		<= (CNTW + 1)'(OUT_DEPTH - 2);

	assign head         = pix_t'(head_bits);
	assign normal_red   = head.red;
	assign normal_green = head.green;
	assign normal_blue  = BLUE_LEVEL;
	assign end_of_image = head.last;

endmodule

>>> design/hnm_chk.sv
// Port-level checker for height_to_normal_map and the bind that attaches it.
// Depends on hnm_pkg.
module hnm_chk import hnm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata,
	input logic              pready,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              action,
	input logic [7:0]        height_sample,
	input logic              pixel_valid,
	input logic              pixel_ready,
	input logic [7:0]        normal_red,
	input logic [7:0]        normal_green,
	input logic [7:0]        normal_blue,
	input logic              end_of_image
);

	// An input transaction that is stalled keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid
			&& $stable({action, height_sample}))
		else $error("stalled input changed");

	// A pixel transaction that is stalled keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid
			&& $stable({normal_red, normal_green, normal_blue, end_of_image}))
		else $error("stalled pixel changed");

	// Both gradient channels stay in the scaling range and blue holds BLUE_LEVEL.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (normal_red >= CH_MIN) && (normal_red <= CH_MAX)
			&& (normal_green >= CH_MIN) && (normal_green <= CH_MAX)
			&& (normal_blue == BLUE_LEVEL))
		else $error("pixel channel out of range");

	// A new pixel shows up only after an input transaction passes stage 1.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("pixel without an input transaction");

	// A written width reads back on the next access.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready
			&& (reg_idx_t'(paddr[APB_AW-1]) == REG_IMAGE_WIDTH))
		##1 (psel && !pwrite && (reg_idx_t'(paddr[APB_AW-1]) == REG_IMAGE_WIDTH))
		|-> prdata == APB_DW'($past(pwdata[CFG_WIDTH_W-1:0])))
		else $error("width register readback mismatch");

endmodule

bind height_to_normal_map hnm_chk u_chk (.*);
